@@ rtl/st2d_pkg.sv @@
package st2d_pkg;

    // grid side and number of power-of-two levels per axis
    localparam int MAX_DIM = 32;
    localparam int LEVELS  = 6;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_BUILD = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_NO_BUILD = 2'd2
    } status_t;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // signed maximum on raw bit patterns
    function automatic logic [63:0] smax(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = ($signed(a) >= $signed(b)) ? a : b;
        return r;
    endfunction

endpackage

@@ rtl/sparse_table_2d_range_max.sv @@
// channel   | dir | tdata fields (low bit up)                    | tuser
// s_axis    | in  | row[4:0] col[9:5] value[73:10] row_end[78:74] | kind[1:0]
//           |     | col_end[83:79], zero fill to 88 bits          |
// m_axis    | out | max_value[63:0]                               | status[1:0]
// cfg       | in  | cfg_we, cfg_index (0 rows_used, 1 cols_used), cfg_data[5:0]
//
// a load, a rejected query or an unused kind goes from S_DECIDE straight to the result in S_OUT
// an ok query makes four reads through the single table read port, each read (S_QRD) followed
// by its fold (S_QACC) through the one shared max unit
// a build walks the level entries of the used grid one at a time, two reads through the same
// read port, one fold through the same max unit and one write each, stepping in S_BNEXT
// rst_n clears control state, the built mark and the result; the table itself is not cleared
// s_axis_tready is low from acceptance until the result transaction leaves m_axis
module sparse_table_2d_range_max (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // row, col, value, row_end, col_end, zero fill
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // max_value
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int DW    = $clog2(st2d_pkg::MAX_DIM);
    localparam int CW    = $clog2(st2d_pkg::MAX_DIM + 1);
    localparam int LW    = $clog2(st2d_pkg::LEVELS);
    localparam int DEPTH = st2d_pkg::LEVELS * st2d_pkg::LEVELS * st2d_pkg::MAX_DIM
                           * st2d_pkg::MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_QRD, S_QACC, S_BRDA, S_BRDB, S_BWAIT, S_BWR, S_BNEXT, S_OUT
    } state_t;

    state_t       state_reg;
    logic         built_reg;
    logic [5:0]   rows_reg, cols_reg;
    logic [1:0]   kind_reg;
    logic [DW-1:0] row_reg, col_reg, rend_reg, cend_reg;
    logic [63:0]  value_reg;
    logic [63:0]  acc_reg, first_reg;
    logic [1:0]   status_reg;
    logic [2:0]   qcnt_reg;    // issued reads
    logic [2:0]   qgot_reg;    // folded reads
    logic [LW-1:0] kr_reg, kc_reg;
    logic [DW-1:0] r2_reg, c2_reg;
    logic          phase_reg;  // 0 row pass, 1 column pass
    logic [LW-1:0] bkr_reg, bkc_reg;
    logic [CW-1:0] br_reg, bc_reg;

    // effective dimensions
    logic [CW-1:0] n_dim, m_dim;
    always_comb
    begin
        n_dim = (rows_reg == 6'd0) ? CW'(1)
              : (32'(rows_reg) > st2d_pkg::MAX_DIM) ? CW'(st2d_pkg::MAX_DIM)
              : CW'(rows_reg);
        m_dim = (cols_reg == 6'd0) ? CW'(1)
              : (32'(cols_reg) > st2d_pkg::MAX_DIM) ? CW'(st2d_pkg::MAX_DIM)
              : CW'(cols_reg);
    end

    function automatic logic [LW-1:0] flog(input logic [CW:0] span);
        logic [LW-1:0] k;
        k = '0;
        for (int i = 1; i < st2d_pkg::LEVELS; i++)
        begin
            if ((32'd1 << i) <= 32'(span))
            begin
                k = LW'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [AW-1:0] slot(input logic [LW-1:0] a, input logic [LW-1:0] b,
                                           input logic [CW-1:0] r, input logic [CW-1:0] c);
        logic [AW+8:0] s;
        s = ((((AW+9)'(a) * (AW+9)'(st2d_pkg::LEVELS)) + (AW+9)'(b))
            * (AW+9)'(st2d_pkg::MAX_DIM) + (AW+9)'(r))
            * (AW+9)'(st2d_pkg::MAX_DIM) + (AW+9)'(c);
        return s[AW-1:0];
    endfunction

    // table memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;

    st2d_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // build step bounds
    logic [CW:0] bspan_c, bspan_r;
    assign bspan_c = (CW+1)'(1) << bkc_reg;
    assign bspan_r = (CW+1)'(1) << bkr_reg;

    // read address select
    always_comb
    begin
        ram_raddr = '0;
        case (state_reg)
            S_QRD:
            begin
                case (qcnt_reg)
                    3'd0:    ram_raddr = slot(kr_reg, kc_reg, CW'(row_reg), CW'(col_reg));
                    3'd1:    ram_raddr = slot(kr_reg, kc_reg, CW'(row_reg), CW'(c2_reg));
                    3'd2:    ram_raddr = slot(kr_reg, kc_reg, CW'(r2_reg), CW'(col_reg));
                    default: ram_raddr = slot(kr_reg, kc_reg, CW'(r2_reg), CW'(c2_reg));
                endcase
            end
            S_BRDA:
            begin
                if (!phase_reg)
                begin
                    ram_raddr = slot('0, bkc_reg - LW'(1), br_reg, bc_reg);
                end
                else
                begin
                    ram_raddr = slot(bkr_reg - LW'(1), bkc_reg, br_reg, bc_reg);
                end
            end
            S_BRDB:
            begin
                if (!phase_reg)
                begin
                    ram_raddr = slot('0, bkc_reg - LW'(1), br_reg,
                                     bc_reg + CW'(bspan_c >> 1));
                end
                else
                begin
                    ram_raddr = slot(bkr_reg - LW'(1), bkc_reg,
                                     br_reg + CW'(bspan_r >> 1), bc_reg);
                end
            end
            default: ram_raddr = '0;
        endcase
    end

    // shared max unit
    logic [63:0] max_out;
    assign max_out = st2d_pkg::smax(first_reg, ram_rdata);

    assign ram_we    = (state_reg == S_BWR) ||
                       (state_reg == S_DECIDE && kind_reg == st2d_pkg::KIND_LOAD &&
                        CW'(row_reg) < n_dim && CW'(col_reg) < m_dim);
    assign ram_waddr = (state_reg == S_BWR) ? slot(bkr_reg, bkc_reg, br_reg, bc_reg)
                     : slot('0, '0, CW'(row_reg), CW'(col_reg));
    assign ram_wdata = (state_reg == S_BWR) ? acc_reg : value_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = acc_reg;
    assign m_axis_tuser  = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            built_reg  <= 1'b0;
            rows_reg   <= 6'd32;
            cols_reg   <= 6'd32;
            status_reg <= st2d_pkg::ST_OK;
            acc_reg    <= '0;
            qcnt_reg   <= '0;
            qgot_reg   <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                built_reg <= 1'b0;
                if (cfg_index == st2d_pkg::REG_ROWS)
                begin
                    rows_reg <= cfg_data;
                end
                else
                begin
                    cols_reg <= cfg_data;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        kind_reg  <= s_axis_tuser;
                        row_reg   <= s_axis_tdata[DW-1:0];
                        col_reg   <= s_axis_tdata[5 +: DW];
                        value_reg <= s_axis_tdata[73:10];
                        rend_reg  <= s_axis_tdata[74 +: DW];
                        cend_reg  <= s_axis_tdata[79 +: DW];
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    acc_reg    <= '0;
                    status_reg <= st2d_pkg::ST_OK;
                    state_reg  <= S_OUT;
                    case (kind_reg)
                        st2d_pkg::KIND_LOAD:
                        begin
                            if (CW'(row_reg) < n_dim && CW'(col_reg) < m_dim)
                            begin
                                built_reg <= 1'b0;
                            end
                            else
                            begin
                                status_reg <= st2d_pkg::ST_BAD;
                            end
                        end
                        st2d_pkg::KIND_BUILD:
                        begin
                            phase_reg <= 1'b0;
                            bkr_reg   <= '0;
                            bkc_reg   <= LW'(1);
                            br_reg    <= '0;
                            bc_reg    <= '0;
                            state_reg <= S_BNEXT;
                        end
                        st2d_pkg::KIND_QUERY:
                        begin
                            if (!built_reg)
                            begin
                                status_reg <= st2d_pkg::ST_NO_BUILD;
                            end
                            else if (row_reg > rend_reg || col_reg > cend_reg ||
                                     CW'(rend_reg) >= n_dim || CW'(cend_reg) >= m_dim)
                            begin
                                status_reg <= st2d_pkg::ST_BAD;
                            end
                            else
                            begin
                                kr_reg <= flog((CW+1)'(rend_reg - row_reg) + 1'b1);
                                kc_reg <= flog((CW+1)'(cend_reg - col_reg) + 1'b1);
                                r2_reg <= DW'(32'(rend_reg) + 1 -
                                         (1 << flog((CW+1)'(rend_reg - row_reg) + 1'b1)));
                                c2_reg <= DW'(32'(cend_reg) + 1 -
                                         (1 << flog((CW+1)'(cend_reg - col_reg) + 1'b1)));
                                qcnt_reg  <= '0;
                                qgot_reg  <= '0;
                                state_reg <= S_QRD;
                            end
                        end
                        default: status_reg <= st2d_pkg::ST_BAD;
                    endcase
                end
                S_QRD:
                begin
                    // read issued this cycle, data next cycle
                    qcnt_reg  <= qcnt_reg + 3'd1;
                    state_reg <= S_QACC;
                end
                S_QACC:
                begin
                    first_reg <= (qgot_reg == 3'd0) ? ram_rdata : max_out;
                    qgot_reg  <= qgot_reg + 3'd1;
                    if (qgot_reg == 3'd3)
                    begin
                        acc_reg   <= max_out;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_QRD;
                    end
                end
                S_BNEXT:
                begin
                    // skip entries and levels outside the used grid
                    if (!phase_reg)
                    begin
                        if (32'(bkc_reg) >= st2d_pkg::LEVELS || bspan_c > (CW+1)'(m_dim) ||
                            br_reg >= n_dim)
                        begin
                            if (br_reg + CW'(1) < n_dim && 32'(bkc_reg) >= 1 &&
                                !(br_reg >= n_dim))
                            begin
                                br_reg  <= br_reg + CW'(1);
                                bkc_reg <= LW'(1);
                                bc_reg  <= '0;
                            end
                            else
                            begin
                                phase_reg <= 1'b1;
                                bkr_reg   <= LW'(1);
                                bkc_reg   <= '0;
                                br_reg    <= '0;
                                bc_reg    <= '0;
                            end
                        end
                        else if ((CW+1)'(bc_reg) + bspan_c > (CW+1)'(m_dim))
                        begin
                            bkc_reg <= bkc_reg + LW'(1);
                            bc_reg  <= '0;
                        end
                        else
                        begin
                            state_reg <= S_BRDA;
                        end
                    end
                    else
                    begin
                        if (32'(bkr_reg) >= st2d_pkg::LEVELS || bspan_r > (CW+1)'(n_dim))
                        begin
                            built_reg <= 1'b1;
                            status_reg <= st2d_pkg::ST_OK;
                            acc_reg   <= '0;
                            state_reg <= S_OUT;
                        end
                        else if (32'(bkc_reg) >= st2d_pkg::LEVELS ||
                                 bspan_c > (CW+1)'(m_dim))
                        begin
                            bkr_reg <= bkr_reg + LW'(1);
                            bkc_reg <= '0;
                            br_reg  <= '0;
                            bc_reg  <= '0;
                        end
                        else if ((CW+1)'(br_reg) + bspan_r > (CW+1)'(n_dim))
                        begin
                            bkc_reg <= bkc_reg + LW'(1);
                            br_reg  <= '0;
                            bc_reg  <= '0;
                        end
                        else if ((CW+1)'(bc_reg) + bspan_c > (CW+1)'(m_dim))
                        begin
                            br_reg <= br_reg + CW'(1);
                            bc_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= S_BRDA;
                        end
                    end
                end
                S_BRDA:  state_reg <= S_BRDB;
                S_BRDB:
                begin
                    first_reg <= ram_rdata;
                    state_reg <= S_BWAIT;
                end
                S_BWAIT:
                begin
                    acc_reg   <= max_out;
                    state_reg <= S_BWR;
                end
                S_BWR:
                begin
                    bc_reg    <= bc_reg + CW'(1);
                    state_reg <= S_BNEXT;
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a result other than ok carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != st2d_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("non-ok result with nonzero value");

    // the input side stays closed while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open while result pending");

    // table writes only during a load decision or a build write
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_BWR || state_reg == S_DECIDE))
        else $error("stray table write");

    // an accepted item is decided in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == S_DECIDE)
        else $error("accepted item not decided");

endmodule

@@ rtl/st2d_ram.sv @@
module st2d_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
